@@ hw/rtl/bbt_pkg.sv @@
// Shared types for the bounded bag table: action codes, token flags
// carried along the cell chain and the packed result record.
// No dependencies.
package bbt_pkg;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_CLEAR  = 2'd3
    } act_t;

    // Flags of the scan token as it moves from cell to cell
    typedef struct packed {
        logic busy;
        logic found;
    } tok_flag_t;

    // Result record, succeeded in the lowest bit
    typedef struct packed {
        logic       bag_empty;
        logic [4:0] bag_size;
        logic       present;
        logic [4:0] occurrences;
        logic       succeeded;
    } res_t;

endpackage

@@ hw/rtl/bbt_cell.sv @@
// One cell of the bag chain: holds one slot, compares it against the key
// as the scan token passes and forwards the updated token. Uses bbt_pkg.
module bbt_cell #(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = 32,
    parameter int CNT_W       = 5,
    parameter int IDX_W       = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [VALUE_WIDTH-1:0] key,
    input  logic [CNT_W-1:0]       live_count,
    input  bbt_pkg::tok_flag_t     flag_in,
    input  logic [CNT_W-1:0]       freq_in,
    input  logic [IDX_W-1:0]       first_in,
    input  logic [VALUE_WIDTH-1:0] last_in,
    output bbt_pkg::tok_flag_t     flag_out,
    output logic [CNT_W-1:0]       freq_out,
    output logic [IDX_W-1:0]       first_out,
    output logic [VALUE_WIDTH-1:0] last_out,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_idx,
    input  logic [VALUE_WIDTH-1:0] wr_val
);
    import bbt_pkg::*;

    logic [VALUE_WIDTH-1:0] slot_reg;
    tok_flag_t              flag_reg;
    logic [CNT_W-1:0]       freq_reg;
    logic [IDX_W-1:0]       first_reg;
    logic [VALUE_WIDTH-1:0] last_reg;
    logic                   is_live;
    logic                   is_match;
    logic                   is_last;

    assign is_live  = CNT_W'(INDEX) < live_count;
    assign is_match = is_live && (slot_reg == key);
    assign is_last  = CNT_W'(INDEX + 1) == live_count;

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_idx == IDX_W'(INDEX))) begin
            slot_reg <= wr_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= '0;
        end else begin
            flag_reg.busy  <= flag_in.busy;
            flag_reg.found <= flag_in.found | is_match;
        end
        freq_reg  <= freq_in + CNT_W'(is_match);
        first_reg <= flag_in.found ? first_in : IDX_W'(INDEX);
        last_reg  <= is_last ? slot_reg : last_in;
    end

    assign flag_out  = flag_reg;
    assign freq_out  = freq_reg;
    assign first_out = first_reg;
    assign last_out  = last_reg;

endmodule

@@ hw/rtl/bounded_bag_table.sv @@
// Bounded bag table: a multiset of up to CAPACITY values held in a chain of cells.
// The scan token advances one cell per cycle from request acceptance to result; a new
// request is accepted only once the scan is over and no result is pending. A finished
// result waits in an output register (plus one pending slot) while the next request
// is accepted.
// Reset (aresetn low, synchronous) empties the bag; slot contents are not cleared.
module bounded_bag_table #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] entry_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] succeeded, [5:1] occurrences, [6] present,
                                   // [11:7] bag_size, [12] bag_empty, [15:13] zero
);
    import bbt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic {S_IDLE, S_SCAN} state_t;

    state_t                 state_reg;
    act_t                   act_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic                   start_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   m_tvalid_reg;
    res_t                   res_reg;
    logic                   pend_valid_reg;
    res_t                   pend_reg;

    // Token chain: element i feeds cell i, element CAPACITY is the tail
    tok_flag_t              ch_flag  [CAPACITY+1];
    logic [CNT_W-1:0]       ch_freq  [CAPACITY+1];
    logic [IDX_W-1:0]       ch_first [CAPACITY+1];
    logic [VALUE_WIDTH-1:0] ch_last  [CAPACITY+1];

    logic                   s_fire;
    logic                   m_fire;
    logic                   finish;
    logic [VALUE_WIDTH+31:0] key_ext;

    // Finishing step
    logic                   fin_ok;
    logic                   fin_found;
    logic [CNT_W-1:0]       fin_freq;
    logic [CNT_W-1:0]       count_next;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    logic [VALUE_WIDTH-1:0] wr_val;
    logic [CNT_W+4:0]       freq_ext;
    logic [CNT_W+4:0]       size_ext;
    res_t                   fin_res;

    assign s_tready = (state_reg == S_IDLE) && !pend_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid_reg && m_tready;
    assign finish   = ch_flag[CAPACITY].busy;

    // Cut or widen the incoming value to the slot width
    assign key_ext = {{VALUE_WIDTH{1'b0}}, s_tdata};

    // Inject a fresh token at the head of the chain
    assign ch_flag[0].busy  = start_reg;
    assign ch_flag[0].found = 1'b0;
    assign ch_freq[0]       = '0;
    assign ch_first[0]      = '0;
    assign ch_last[0]       = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        bbt_cell #(
            .INDEX      (i),
            .VALUE_WIDTH(VALUE_WIDTH),
            .CNT_W      (CNT_W),
            .IDX_W      (IDX_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key       (key_reg),
            .live_count(count_reg),
            .flag_in   (ch_flag[i]),
            .freq_in   (ch_freq[i]),
            .first_in  (ch_first[i]),
            .last_in   (ch_last[i]),
            .flag_out  (ch_flag[i+1]),
            .freq_out  (ch_freq[i+1]),
            .first_out (ch_first[i+1]),
            .last_out  (ch_last[i+1]),
            .wr_en     (wr_en),
            .wr_idx    (wr_idx),
            .wr_val    (wr_val)
        );
    end

    // Apply the action once the token has passed every cell
    always_comb begin
        fin_ok     = 1'b0;
        fin_found  = ch_flag[CAPACITY].found;
        fin_freq   = ch_freq[CAPACITY];
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_idx     = count_reg[IDX_W-1:0];
        wr_val     = key_reg;
        case (act_reg)
            ACT_ADD: begin
                // add to a full bag stores nothing
                fin_ok     = count_reg < CNT_W'(CAPACITY);
                count_next = fin_ok ? count_reg + CNT_W'(1) : count_reg;
                wr_en      = finish && fin_ok;
            end
            ACT_REMOVE: begin
                // move the last live entry into the first match
                fin_ok     = fin_found;
                count_next = fin_found ? count_reg - CNT_W'(1) : count_reg;
                wr_en      = finish && fin_found;
                wr_idx     = ch_first[CAPACITY];
                wr_val     = ch_last[CAPACITY];
            end
            ACT_QUERY: begin
                fin_ok = fin_found;
            end
            default: begin
                fin_ok     = 1'b1;
                fin_found  = 1'b0;
                fin_freq   = '0;
                count_next = '0;
            end
        endcase
        freq_ext            = {5'b0, fin_freq};
        size_ext            = {5'b0, count_next};
        fin_res.succeeded   = fin_ok;
        fin_res.occurrences = freq_ext[4:0];
        fin_res.present     = fin_found;
        fin_res.bag_size    = size_ext[4:0];
        fin_res.bag_empty   = count_next == '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            start_reg      <= 1'b0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            start_reg <= s_fire;
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        state_reg <= S_SCAN;
                        act_reg   <= act_t'(s_tuser);
                        key_reg   <= key_ext[VALUE_WIDTH-1:0];
                    end
                end
                S_SCAN: begin
                    if (finish) begin
                        state_reg <= S_IDLE;
                        count_reg <= count_next;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Output register with one pending slot behind it
            if (finish) begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_reg <= 1'b1;
                    res_reg      <= fin_res;
                end else begin
                    pend_valid_reg <= 1'b1;
                    pend_reg       <= fin_res;
                end
            end else if (m_fire) begin
                if (pend_valid_reg) begin
                    res_reg        <= pend_reg;
                    pend_valid_reg <= 1'b0;
                end else begin
                    m_tvalid_reg <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, res_reg};

`ifndef SYNTHESIS
    a_tail_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> (state_reg == S_SCAN))
        else $error("scan token left the chain outside a scan");
    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> m_tvalid_reg)
        else $error("pending result without a held output");
    a_start_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (start_reg && state_reg == S_SCAN))
        else $error("accepted request did not start a scan");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (count_reg <= CNT_W'(CAPACITY)))
        else $error("live count beyond capacity");
`endif

endmodule
